FILE: src/cgc_pkg.sv
// ----------------------------------------------------------------------------
// cgc_pkg: shared constants and tables for the crossover gain curve
// log2 and exp2 interpolation tables, register indexes, fixed-point limits
// ----------------------------------------------------------------------------
package cgc_pkg;

    localparam int MAX_RANK = 16;
    localparam logic [24:0] ONE_Q24 = 25'd16777216;
    localparam logic [24:0] HALF_Q24 = 25'd8388608;
    localparam logic [22:0] D_CAP = 23'd4194304;
    localparam logic [15:0] GENTLE_LIMIT = 16'hFD00;
    localparam logic [13:0] SLOPE_K = 14'd10885;
    localparam logic [15:0] M6_K = 16'd65312;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_CUTOFF = 3'd0,
        REG_SLOPE  = 3'd1,
        REG_RATE   = 3'd2,
        REG_RANK   = 3'd3,
        REG_KIND   = 3'd4,
        REG_MODE   = 3'd5,
        REG_SOURCE = 3'd6
    } t_reg_idx;

    // log2(1+i/16) in Q16
    function automatic logic [16:0] log_tab(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:  v = 17'd0;
            5'd1:  v = 17'd5732;
            5'd2:  v = 17'd11136;
            5'd3:  v = 17'd16248;
            5'd4:  v = 17'd21098;
            5'd5:  v = 17'd25711;
            5'd6:  v = 17'd30109;
            5'd7:  v = 17'd34312;
            5'd8:  v = 17'd38336;
            5'd9:  v = 17'd42196;
            5'd10: v = 17'd45904;
            5'd11: v = 17'd49472;
            5'd12: v = 17'd52911;
            5'd13: v = 17'd56229;
            5'd14: v = 17'd59434;
            5'd15: v = 17'd62534;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    // 2^(-i/16) in Q24
    function automatic logic [24:0] exp_tab(input logic [4:0] i);
        logic [24:0] v;
        case (i)
            5'd0:  v = 25'd16777216;
            5'd1:  v = 25'd16065917;
            5'd2:  v = 25'd15384775;
            5'd3:  v = 25'd14732511;
            5'd4:  v = 25'd14107901;
            5'd5:  v = 25'd13509772;
            5'd6:  v = 25'd12937002;
            5'd7:  v = 25'd12388516;
            5'd8:  v = 25'd11863283;
            5'd9:  v = 25'd11360319;
            5'd10: v = 25'd10878679;
            5'd11: v = 25'd10417458;
            5'd12: v = 25'd9975792;
            5'd13: v = 25'd9552852;
            5'd14: v = 25'd9147842;
            5'd15: v = 25'd8760003;
            default: v = 25'd8388608;
        endcase
        return v;
    endfunction

endpackage

FILE: src/crossover_gain_curve_top.sv
// ----------------------------------------------------------------------------
// crossover_gain_curve_top: streaming crossover gain per frequency or bin
// log2 of frequency and cutoff, slope scaling, exp2 and combine, pipelined
// ----------------------------------------------------------------------------
// channel  | signals                                   | direction
// input    | i_start, o_busy, i_frequency, i_bin_index,| in
//          | i_gain_in, i_last_in                      |
// result   | o_valid, o_gain_out, o_last_out           | out
// config   | i_cfg_valid, o_cfg_ready, i_cfg_index,    | in
//          | i_cfg_data                                |
//
// one item per cycle; each start transaction passes through the nine register
// stages of the log/exp datapath before its result appears
// i_rst_n synchronous active low clears valid bits and loads register resets
// o_busy is always low; the receiver takes every result as it appears
// cutoff log2 is recomputed in the pipe alongside each item
// ----------------------------------------------------------------------------
module crossover_gain_curve_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [25:0] i_frequency,
    input  logic [15:0] i_bin_index,
    input  logic [24:0] i_gain_in,
    input  logic        i_last_in,
    output logic        o_valid,
    output logic [24:0] o_gain_out,
    output logic        o_last_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // configuration registers
    logic [25:0] r_cutoff;
    logic [15:0] r_slope;
    logic [18:0] r_rate;
    logic [4:0]  r_rank;
    logic        r_kind, r_mode, r_source;

    assign o_cfg_ready = 1'b1;
    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= 26'd256000;
            r_slope  <= 16'hE800;
            r_rate   <= 19'd48000;
            r_rank   <= 5'd10;
            r_kind   <= 1'b0;
            r_mode   <= 1'b0;
            r_source <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cgc_pkg::REG_CUTOFF: r_cutoff <= i_cfg_data[25:0];
                cgc_pkg::REG_SLOPE:  r_slope  <= i_cfg_data[15:0];
                cgc_pkg::REG_RATE:   r_rate   <= i_cfg_data[18:0];
                cgc_pkg::REG_RANK:   r_rank   <= i_cfg_data[4:0];
                cgc_pkg::REG_KIND:   r_kind   <= i_cfg_data[0];
                cgc_pkg::REG_MODE:   r_mode   <= i_cfg_data[0];
                cgc_pkg::REG_SOURCE: r_source <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // leading-one position and 16-bit fraction of a 35-bit value
    function automatic logic [21:0] lead_frac(input logic [34:0] x);
        logic [5:0]  p;
        logic [15:0] fr;
        logic [50:0] xs;
        p = 6'd0;
        for (int k = 0; k < 35; k++) begin
            if (x[k]) p = 6'(k);
        end
        xs = {x, 16'd0} >> p;
        fr = xs[15:0];
        return {p, fr};
    endfunction

    // stage valid bits, one per register stage
    logic [8:0] r_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else          r_v <= {r_v[7:0], i_start};
    end

    // ---- stage 1: capture, bin folding, gain clamp
    logic [4:0]  s1_rank;
    logic [15:0] s1_mask, s1_i;
    logic [16:0] s1_sz;
    logic [15:0] r1_i;
    logic [4:0]  r1_rank;
    logic [25:0] r1_freq;
    logic [24:0] r1_gin;
    logic        r1_last, r1_bin, r1_zero;

    always_comb begin
        s1_rank = r_rank;
        if (r_rank == 5'd0) s1_rank = 5'd1;
        if (r_rank > 5'(cgc_pkg::MAX_RANK)) s1_rank = 5'(cgc_pkg::MAX_RANK);
        s1_sz   = 17'd1 << s1_rank;
        s1_mask = 16'(s1_sz - 17'd1);
        s1_i    = i_bin_index & s1_mask;
        if (17'(s1_i) > (s1_sz >> 1)) s1_i = 16'(s1_sz - 17'(s1_i));
    end

    always_ff @(posedge i_clk) begin
        r1_i    <= s1_i;
        r1_rank <= s1_rank;
        r1_freq <= i_frequency;
        r1_gin  <= (i_gain_in > cgc_pkg::ONE_Q24) ? cgc_pkg::ONE_Q24 : i_gain_in;
        r1_last <= i_last_in;
        r1_bin  <= r_source;
        r1_zero <= r_source && ((i_bin_index & s1_mask) == 16'd0);
    end

    // ---- stage 2: bin frequency multiply, frequency select
    logic [34:0] r2_f;
    logic [24:0] r2_gin;
    logic        r2_last, r2_zero;
    logic [42:0] s2_prod;
    always_comb s2_prod = ({8'd0, 16'(r1_i) * 35'(r_rate)} << 8) >> r1_rank;
    always_ff @(posedge i_clk) begin
        r2_f    <= r1_bin ? s2_prod[34:0] : 35'(r1_freq);
        r2_gin  <= r1_gin;
        r2_last <= r1_last;
        r2_zero <= r1_zero;
    end

    // ---- stage 3: leading-one search and table lookups
    logic [21:0] s3_lf, s3_lc;
    logic [5:0]  r3_pf, r3_pc;
    logic [16:0] r3_tf0, r3_tf1, r3_tc0, r3_tc1;
    logic [11:0] r3_rf, r3_rc;
    logic        r3_fz, r3_cz, r3_above, r3_le, r3_ge2, r3_ge, r3_le2;
    logic [24:0] r3_gin;
    logic        r3_last, r3_zero;
    always_comb begin
        s3_lf = lead_frac(r2_f);
        s3_lc = lead_frac(35'(r_cutoff));
    end
    always_ff @(posedge i_clk) begin
        r3_pf  <= s3_lf[21:16];
        r3_pc  <= s3_lc[21:16];
        r3_tf0 <= cgc_pkg::log_tab({1'b0, s3_lf[15:12]});
        r3_tf1 <= cgc_pkg::log_tab(5'({1'b0, s3_lf[15:12]} + 5'd1));
        r3_tc0 <= cgc_pkg::log_tab({1'b0, s3_lc[15:12]});
        r3_tc1 <= cgc_pkg::log_tab(5'({1'b0, s3_lc[15:12]} + 5'd1));
        r3_rf  <= s3_lf[11:0];
        r3_rc  <= s3_lc[11:0];
        r3_fz  <= (r2_f == '0);
        r3_cz  <= (r_cutoff == '0);
        r3_above <= r2_f >= 35'(r_cutoff);
        r3_le  <= r2_f <= 35'(r_cutoff);
        r3_ge2 <= r2_f >= {8'd0, r_cutoff, 1'b0};
        r3_ge  <= r2_f >= 35'(r_cutoff);
        r3_le2 <= {r2_f, 1'b0} <= 36'(r_cutoff);
        r3_gin <= r2_gin;
        r3_last <= r2_last;
        r3_zero <= r2_zero;
    end

    // ---- stage 4: interpolated logs and distance
    logic signed [23:0] s4_lf, s4_lc, s4_diff;
    logic [28:0] s4_if, s4_ic;
    logic [22:0] r4_d;
    logic        r4_above, r4_le, r4_ge2, r4_ge, r4_le2;
    logic [24:0] r4_gin;
    logic        r4_last, r4_zero;
    always_comb begin
        s4_if = 29'(r3_tf1 - r3_tf0) * 29'(r3_rf);
        s4_ic = 29'(r3_tc1 - r3_tc0) * 29'(r3_rc);
        s4_lf = r3_fz ? -24'sd2097152 :
                $signed({2'b0, r3_pf, 16'd0}) + $signed(24'(r3_tf0))
                + $signed(24'(s4_if[28:12]));
        s4_lc = r3_cz ? -24'sd2097152 :
                $signed({2'b0, r3_pc, 16'd0}) + $signed(24'(r3_tc0))
                + $signed(24'(s4_ic[28:12]));
        s4_diff = s4_lf - s4_lc;
        if (s4_diff < 0) s4_diff = -s4_diff;
    end
    always_ff @(posedge i_clk) begin
        r4_d     <= (s4_diff > $signed({1'b0, cgc_pkg::D_CAP})) ? cgc_pkg::D_CAP
                                                                 : s4_diff[22:0];
        r4_above <= r3_above;
        r4_le    <= r3_le;
        r4_ge2   <= r3_ge2;
        r4_ge    <= r3_ge;
        r4_le2   <= r3_le2;
        r4_gin   <= r3_gin;
        r4_last  <= r3_last;
        r4_zero  <= r3_zero;
    end

    // ---- stage 5: slope times constant, gentle exponent
    logic [29:0] r5_sk;
    logic [22:0] r5_d;
    logic [38:0] s5_m6;
    logic [16:0] r5_eg;
    logic        r5_gentle;
    logic        r5_above, r5_le, r5_ge2, r5_ge, r5_le2;
    logic [24:0] r5_gin;
    logic        r5_last, r5_zero;
    always_comb s5_m6 = 39'(cgc_pkg::M6_K) * 39'(r4_d);
    always_ff @(posedge i_clk) begin
        r5_sk    <= 30'(17'(-{r_slope[15], r_slope})) * 30'(cgc_pkg::SLOPE_K);
        r5_d     <= r4_d;
        r5_eg    <= (s5_m6[38:16] > 23'd65536) ? 17'd65536 : s5_m6[32:16];
        r5_gentle <= $signed(r_slope) > $signed(cgc_pkg::GENTLE_LIMIT);
        r5_above <= r4_above;
        r5_le    <= r4_le;
        r5_ge2   <= r4_ge2;
        r5_ge    <= r4_ge;
        r5_le2   <= r4_le2;
        r5_gin   <= r4_gin;
        r5_last  <= r4_last;
        r5_zero  <= r4_zero;
    end

    // ---- stage 6: exponent product and exp argument
    logic [52:0] s6_e;
    logic [29:0] r6_arg;
    logic        r6_gentle;
    logic        r6_above, r6_le, r6_ge2, r6_ge, r6_le2;
    logic [24:0] r6_gin;
    logic        r6_last, r6_zero;
    always_comb s6_e = 53'(r5_sk) * 53'(r5_d);
    always_ff @(posedge i_clk) begin
        r6_arg    <= r5_gentle ? 30'(17'd65536 - r5_eg)
                               : 30'(s6_e[52:24]) + 30'd65536;
        r6_gentle <= r5_gentle;
        r6_above  <= r5_above;
        r6_le     <= r5_le;
        r6_ge2    <= r5_ge2;
        r6_ge     <= r5_ge;
        r6_le2    <= r5_le2;
        r6_gin    <= r5_gin;
        r6_last   <= r5_last;
        r6_zero   <= r5_zero;
    end

    // ---- stage 7: exp2 interpolation and shift
    logic [24:0] s7_t0, s7_t1, s7_v;
    logic [36:0] s7_m;
    logic [24:0] r7_p;
    logic        r7_gentle;
    logic        r7_above, r7_le, r7_ge2, r7_ge, r7_le2;
    logic [24:0] r7_gin;
    logic        r7_last, r7_zero;
    always_comb begin
        s7_t0 = cgc_pkg::exp_tab({1'b0, r6_arg[15:12]});
        s7_t1 = cgc_pkg::exp_tab(5'({1'b0, r6_arg[15:12]} + 5'd1));
        s7_m  = 37'(s7_t0 - s7_t1) * 37'(r6_arg[11:0]);
        s7_v  = s7_t0 - 25'(s7_m[36:12]);
    end
    always_ff @(posedge i_clk) begin
        r7_p      <= (r6_arg[29:16] >= 14'd25) ? 25'd0 : (s7_v >> r6_arg[20:16]);
        r7_gentle <= r6_gentle;
        r7_above  <= r6_above;
        r7_le     <= r6_le;
        r7_ge2    <= r6_ge2;
        r7_ge     <= r6_ge;
        r7_le2    <= r6_le2;
        r7_gin    <= r6_gin;
        r7_last   <= r6_last;
        r7_zero   <= r6_zero;
    end

    // ---- stage 8: branch selection and bin zero
    logic [24:0] s8_g, r8_g;
    logic        r8_mul, r8_last;
    logic [24:0] r8_gin;
    always_comb begin
        if (r7_gentle) begin
            s8_g = (r7_p > cgc_pkg::ONE_Q24) ? cgc_pkg::ONE_Q24 : r7_p;
            if (!r_kind) begin
                if (r7_le) s8_g = cgc_pkg::HALF_Q24;
                else if (r7_ge2) s8_g = cgc_pkg::ONE_Q24;
            end else begin
                if (r7_ge) s8_g = cgc_pkg::HALF_Q24;
                else if (r7_le2) s8_g = cgc_pkg::ONE_Q24;
            end
        end else if (r_kind ^ r7_above) begin
            s8_g = cgc_pkg::ONE_Q24 - r7_p;
        end else begin
            s8_g = r7_p;
        end
    end
    always_ff @(posedge i_clk) begin
        if (r7_zero) begin
            r8_g   <= r_kind ? (r_mode ? r7_gin : cgc_pkg::ONE_Q24) : 25'd0;
            r8_mul <= 1'b0;
        end else begin
            r8_g   <= s8_g;
            r8_mul <= r_mode;
        end
        r8_gin  <= r7_gin;
        r8_last <= r7_last;
    end

    // ---- stage 9: apply-mode multiply, output register
    logic [49:0] s9_m;
    logic [24:0] r9_g;
    logic        r9_last;
    always_comb s9_m = 50'(r8_gin) * 50'(r8_g);
    always_ff @(posedge i_clk) begin
        r9_g    <= r8_mul ? s9_m[48:24] : r8_g;
        r9_last <= r8_last;
    end

    assign o_valid    = r_v[8];
    assign o_gain_out = r9_g;
    assign o_last_out = r9_last;

    // result never exceeds one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_gain_out <= cgc_pkg::ONE_Q24)
        else $error("gain above one");
    // each start gives a result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> ##8 o_valid)
        else $error("lost result");
    // no result without a start
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_v[7]))
        else $error("spurious result");

endmodule

FILE: verif/tb_crossover_gain_curve_top.sv
// ----------------------------------------------------------------------------
// tb_crossover_gain_curve_top: self-checking bench for the crossover gain curve
// Runs directed and random frequency/bin items over several register settings,
// predicts each gain with a bit-exact fixed-point curve model and compares
// every result transaction in order; sender idling varies per phase.
// ----------------------------------------------------------------------------
module tb_crossover_gain_curve_top;

    localparam int NUM_PHASES = 12;
    localparam int RANDOM_PER_PHASE = 160;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PIPE_SETTLE = 16;

    typedef struct packed {
        logic [25:0] frequency;
        logic [15:0] bin_index;
        logic [24:0] gain_in;
        logic        last_in;
    } t_gain_req;

    typedef struct packed {
        logic [24:0] gain;
        logic        last;
    } t_gain_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [25:0] i_frequency;
    logic [15:0] i_bin_index;
    logic [24:0] i_gain_in;
    logic        i_last_in;
    logic        o_valid;
    logic [24:0] o_gain_out;
    logic        o_last_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    // log2(1+i/16) in Q16 and 2^(-i/16) in Q24
    longint unsigned log_pts[17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312,
        38336, 42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
    longint unsigned exp_pts[17] = '{16777216, 16065917, 15384775, 14732511, 14107901,
        13509772, 12937002, 12388516, 11863283, 11360319, 10878679, 10417458, 9975792,
        9552852, 9147842, 8760003, 8388608};

    // shadow of the configuration registers
    logic [25:0]        cutoff_sh;
    logic signed [15:0] slope_sh;
    logic [18:0]        rate_sh;
    logic [4:0]         rank_sh;
    logic               kind_sh;
    logic               mode_sh;
    logic               source_sh;

    t_gain_req pending_reqs[$];
    t_gain_res expected_gains[$];
    t_gain_req driven_req;
    int        sender_idle_pct;
    bit        sender_hold;
    int        err_count;
    int        cycle_count;

    crossover_gain_curve_top uut (.*);

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint log2_fix(longint unsigned x);
        int p;
        longint unsigned fr, idx, rem;
        if (x == 0) return -(32 * 65536);
        p = 0;
        while (p < 63 && (x >> (p + 1)) != 0) p++;
        if (p >= 16) fr = (x >> (p - 16)) & 64'hFFFF;
        else fr = (x << (16 - p)) & 64'hFFFF;
        idx = fr >> 12;
        rem = fr & 64'hFFF;
        return longint'(p) * 65536 + longint'(log_pts[idx]) +
               longint'(((log_pts[idx + 1] - log_pts[idx]) * rem) >> 12);
    endfunction

    function automatic longint unsigned exp2_neg(longint unsigned e);
        longint unsigned n, idx, rem, v;
        n = e >> 16;
        idx = (e & 64'hFFFF) >> 12;
        rem = e & 64'hFFF;
        if (n >= 25) return 0;
        v = exp_pts[idx] - (((exp_pts[idx] - exp_pts[idx + 1]) * rem) >> 12);
        return v >> n;
    endfunction

    function automatic longint unsigned curve_at(longint unsigned f, longint unsigned f0);
        longint diff;
        longint unsigned d, p, e, one;
        int s;
        bit above;
        one = 64'd16777216;
        diff = log2_fix(f) - log2_fix(f0);
        d = (diff < 0) ? -diff : diff;
        above = (f >= f0);
        s = slope_sh;
        if (d > 64 * 65536) d = 64 * 65536;
        // gentle slope: clamped -6 dB/oct shape
        if (s > -768) begin
            if (kind_sh == 1'b0) begin
                if (f <= f0) return one / 2;
                if (f >= 2 * f0) return one;
            end else begin
                if (f >= f0) return one / 2;
                if (2 * f <= f0) return one;
            end
            e = (64'd65312 * d) >> 16;
            if (e > 65536) e = 65536;
            p = exp2_neg(65536 - e);
            return (p > one) ? one : p;
        end
        e = (longint'(-s) * 64'd10885 * d) >> 24;
        p = exp2_neg(e + 65536);
        if (kind_sh == 1'b0) return above ? one - p : p;
        return above ? p : one - p;
    endfunction

    function automatic t_gain_res predict_gain(t_gain_req r);
        t_gain_res res;
        longint unsigned gin, f, g, size, i;
        int rank;
        gin = r.gain_in;
        if (gin > 64'd16777216) gin = 64'd16777216;
        res.last = r.last_in;
        if (source_sh) begin
            rank = rank_sh;
            if (rank < 1) rank = 1;
            if (rank > 16) rank = 16;
            size = 64'd1 << rank;
            i = r.bin_index & (size - 1);
            // bin zero bypasses the curve
            if (i == 0) begin
                if (kind_sh == 1'b0) res.gain = '0;
                else res.gain = mode_sh ? gin[24:0] : cgc_pkg::ONE_Q24;
                return res;
            end
            if (i > (size >> 1)) i = size - i;
            f = ((i * rate_sh) << 8) >> rank;
        end else begin
            f = r.frequency;
        end
        g = curve_at(f, cutoff_sh);
        if (mode_sh) g = (gin * g) >> 24;
        res.gain = g[24:0];
        return res;
    endfunction

    // driver: accepts on start && !busy, then presents the next pending item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) expected_gains.push_back(predict_gain(driven_req));
            if (i_start && o_busy) begin
                i_start <= 1'b1;
            end else if (pending_reqs.size() > 0 && !sender_hold &&
                         $urandom_range(0, 99) >= sender_idle_pct) begin
                driven_req = pending_reqs.pop_front();
                i_start <= 1'b1;
                i_frequency <= driven_req.frequency;
                i_bin_index <= driven_req.bin_index;
                i_gain_in <= driven_req.gain_in;
                i_last_in <= driven_req.last_in;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: register shadow and result checking
    always @(posedge i_clk) begin
        t_gain_res want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (cgc_pkg::t_reg_idx'(i_cfg_index))
                    cgc_pkg::REG_CUTOFF: cutoff_sh <= i_cfg_data[25:0];
                    cgc_pkg::REG_SLOPE:  slope_sh <= i_cfg_data[15:0];
                    cgc_pkg::REG_RATE:   rate_sh <= i_cfg_data[18:0];
                    cgc_pkg::REG_RANK:   rank_sh <= i_cfg_data[4:0];
                    cgc_pkg::REG_KIND:   kind_sh <= i_cfg_data[0];
                    cgc_pkg::REG_MODE:   mode_sh <= i_cfg_data[0];
                    cgc_pkg::REG_SOURCE: source_sh <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (o_valid) begin
                if (expected_gains.size() == 0) begin
                    $display("%0t: unexpected result gain=%0d last=%0b",
                             $time, o_gain_out, o_last_out);
                    err_count++;
                end else begin
                    want = expected_gains.pop_front();
                    if (o_gain_out !== want.gain) begin
                        $display("%0t: gain mismatch expected %0d actual %0d",
                                 $time, want.gain, o_gain_out);
                        err_count++;
                    end
                    if (o_last_out !== want.last) begin
                        $display("%0t: last mismatch expected %0b actual %0b",
                                 $time, want.last, o_last_out);
                        err_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[crossover_gain_curve_top] ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || i_start || expected_gains.size() != 0);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    // one config transaction, upper data bits random
    task automatic write_reg(cgc_pkg::t_reg_idx idx, logic [31:0] value,
                             logic [31:0] mask);
        while ($urandom_range(0, 3) == 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= ($urandom() & ~mask) | (value & mask);
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [25:0] pick_frequency();
        longint f;
        longint c;
        c = cutoff_sh;
        case ($urandom_range(0, 7))
            0: f = c + $signed($urandom_range(0, 64)) - 32;
            1: f = 2 * c + $signed($urandom_range(0, 64)) - 32;
            2: f = c / 2 + $signed($urandom_range(0, 64)) - 32;
            3: f = $urandom_range(0, 1) ? 0 : 26'h3FFFFFF;
            4: f = $urandom_range(0, 255);
            5: f = $urandom() >> $urandom_range(6, 31);
            default: f = $urandom();
        endcase
        if (f < 0) f = 0;
        return f[25:0];
    endfunction

    function automatic t_gain_req random_req();
        t_gain_req r;
        r.frequency = pick_frequency();
        case ($urandom_range(0, 5))
            0: r.bin_index = 16'd0;
            1: r.bin_index = 16'd1 << $urandom_range(0, 15);
            2: r.bin_index = (16'd1 << $urandom_range(0, 15)) + 16'd1;
            3: r.bin_index = $urandom() >> $urandom_range(16, 31);
            default: r.bin_index = $urandom();
        endcase
        case ($urandom_range(0, 4))
            0: r.gain_in = cgc_pkg::ONE_Q24;
            1: r.gain_in = $urandom_range(0, 1) ? 25'd0 : 25'h1FFFFFF;
            2: r.gain_in = $urandom_range(0, 16777216);
            default: r.gain_in = $urandom();
        endcase
        r.last_in = $urandom_range(0, 1);
        return r;
    endfunction

    // stimulus
    initial begin
        int cut_opts[5];
        int slope_opts[7];
        int rate_opts[4];
        t_gain_req r;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_frequency = '0;
        i_bin_index = '0;
        i_gain_in = '0;
        i_last_in = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = cgc_pkg::REG_CUTOFF;
        i_cfg_data = '0;
        sender_idle_pct = 0;
        sender_hold = 1'b0;
        err_count = 0;
        cycle_count = 0;
        cutoff_sh = 26'd256000;
        slope_sh = -16'sd6144;
        rate_sh = 19'd48000;
        rank_sh = 5'd10;
        kind_sh = 1'b0;
        mode_sh = 1'b0;
        source_sh = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            cut_opts = '{1, 67108863, 256000, $urandom_range(256, 5000000),
                         $urandom_range(1, 67108863)};
            slope_opts = '{-32768, 0, -768, -767, -769, -6144,
                           -$urandom_range(0, 32768)};
            rate_opts = '{1, 384000, 48000, $urandom_range(1, 384000)};
            // phase 0 runs on reset values
            if (ph > 0) begin
                write_reg(cgc_pkg::REG_CUTOFF, cut_opts[ph % 5], 32'h3FFFFFF);
                write_reg(cgc_pkg::REG_SLOPE, slope_opts[(ph * 3) % 7], 32'hFFFF);
                write_reg(cgc_pkg::REG_RATE, rate_opts[ph % 4], 32'h7FFFF);
                write_reg(cgc_pkg::REG_RANK, (ph % 3 == 0) ? $urandom_range(0, 31) :
                          ((ph % 3 == 1) ? 1 : 16), 32'h1F);
                write_reg(cgc_pkg::REG_KIND, (ph >> 1) & 1, 32'h1);
                write_reg(cgc_pkg::REG_MODE, (ph >> 2) & 1, 32'h1);
                write_reg(cgc_pkg::REG_SOURCE, (ph & 1) | (ph > 7), 32'h1);
                wait_drained();
            end
            case (ph % 4)
                0: sender_idle_pct = 0;
                1: sender_idle_pct = 74;
                2: sender_idle_pct = 37;
                default: sender_idle_pct = $urandom_range(0, 1) ? 0 : 74;
            endcase

            // directed extremes in the early phases
            if (ph < 4) begin
                for (int k = 0; k < 6; k++) begin
                    r.frequency = (k == 0) ? 26'd0 : (k == 1) ? 26'h3FFFFFF :
                                  (k == 2) ? cutoff_sh : (k == 3) ? cutoff_sh - 1 :
                                  (k == 4) ? 26'(cutoff_sh * 2) : 26'(cutoff_sh / 2);
                    r.bin_index = (k == 0) ? 16'd0 : (k == 1) ? 16'hFFFF :
                                  (k == 2) ? 16'd512 : (k == 3) ? 16'd513 :
                                  (k == 4) ? 16'd1024 : 16'd1;
                    r.gain_in = (k == 0) ? 25'd0 : (k == 1) ? 25'h1FFFFFF :
                                (k == 2) ? cgc_pkg::ONE_Q24 : 25'(k * 1234567);
                    r.last_in = k[0];
                    pending_reqs.push_back(r);
                end
            end

            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                pending_reqs.push_back(random_req());
                // in phase 2, for each of the first four items, drain the pipe, then hold the sender
                if (ph == 2 && n < 4) begin
                    wait_drained();
                    sender_hold = 1'b1;
                    repeat ($urandom_range(1, 5)) @(posedge i_clk);
                    sender_hold = 1'b0;
                end
            end
            wait_drained();
        end

        if (err_count == 0) begin
            $display("[crossover_gain_curve_top] OK");
        end else begin
            $display("[crossover_gain_curve_top] ERROR");
        end
        $finish;
    end

endmodule
